// ===== rtl/owm_pkg.sv =====
// Shared types and constants for the omni-wheel mixer and PWM framer.
// Depends on nothing; every other file takes names from here by scope.
package owm_pkg;

	// Field widths
	localparam int VEL_W   = 16;
	localparam int COEF_W  = 16;
	localparam int DB_W    = 8;
	localparam int SPEED_W = 18;
	localparam int PROD_W  = COEF_W + VEL_W + 1;

	// Operation codes of an input word
	localparam logic OP_CMD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SIN      = 2'd0;
	localparam logic [1:0] CFG_COS      = 2'd1;
	localparam logic [1:0] CFG_DEADBAND = 2'd2;

	// Register reset values
	localparam logic [COEF_W-1:0] SIN_RESET      = 16'd23170;
	localparam logic [COEF_W-1:0] COS_RESET      = 16'd23170;
	localparam logic [DB_W-1:0]   DEADBAND_RESET = 8'd40;

	// Velocity limit (one in Q2.14)
	localparam logic signed [VEL_W-1:0] VEL_ONE = 16'sd16384;

	// Frame layout
	localparam logic [7:0] BYTE_OPEN  = 8'h3C;
	localparam logic [7:0] BYTE_MOTOR = 8'h6D;
	localparam logic [7:0] BYTE_CLOSE = 8'h3E;
	localparam logic [7:0] PWM_FULL   = 8'd255;
	localparam logic [2:0] IDX_OPEN   = 3'd0;
	localparam logic [2:0] IDX_MOTOR  = 3'd1;
	localparam logic [2:0] IDX_DIR    = 3'd2;
	localparam logic [2:0] IDX_CLOSE  = 3'd7;

	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef struct packed {
		logic                    op;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_rot;
	} in_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_WHEEL,
		ST_CHECK,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/omni_wheel_mixer_pwm_framer_top.sv =====
// Omni-wheel mixer: a command word stores clamped velocities as it is accepted.
// A tick runs the arithmetic (two passes of the shared multiplier,
// four passes of the wheel adder, one check), then emits eight frame bytes,
// one per cycle while out_ready is high; an unchanged tick ends after the check.
// Input is not ready from a tick's acceptance until its last byte is taken,
// or until the check ends a tick whose speeds are unchanged.
// Asynchronous reset restores register defaults, clears stored velocities and last sent speeds.
module omni_wheel_mixer_pwm_framer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  owm_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output owm_pkg::out_word_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [owm_pkg::COEF_W-1:0]    cfg_data
);

	localparam int SUM_W = owm_pkg::PROD_W + 2;
	localparam int SHR_W = SUM_W - 14;

	owm_pkg::state_t                     state_q, state_d;
	logic [owm_pkg::COEF_W-1:0]          sin_q, cos_q;
	logic [owm_pkg::DB_W-1:0]            deadband_q;
	logic signed [owm_pkg::VEL_W-1:0]    vel_q [3];
	owm_pkg::speed_t                     sent_q [4];
	logic signed [owm_pkg::PROD_W-1:0]   px_q, py_q, product;
	logic [1:0]                          wheel_q;
	logic [2:0]                          byte_q;
	logic                                diff_q;
	logic signed [SUM_W-1:0]             rot_ext, px_ext, py_ext, sum;
	logic signed [SHR_W-1:0]             shr;
	owm_pkg::speed_t                     speed;
	logic                                in_acc;

	function automatic logic signed [owm_pkg::VEL_W-1:0] clamp_vel(
		input logic signed [owm_pkg::VEL_W-1:0] v);
		if (v > owm_pkg::VEL_ONE) begin
			return owm_pkg::VEL_ONE;
		end else if (v < -owm_pkg::VEL_ONE) begin
			return -owm_pkg::VEL_ONE;
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_q      <= owm_pkg::SIN_RESET;
			cos_q      <= owm_pkg::COS_RESET;
			deadband_q <= owm_pkg::DEADBAND_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				owm_pkg::CFG_SIN:      sin_q      <= cfg_data;
				owm_pkg::CFG_COS:      cos_q      <= cfg_data;
				owm_pkg::CFG_DEADBAND: deadband_q <= cfg_data[owm_pkg::DB_W-1:0];
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			owm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_data.op == owm_pkg::OP_TICK) begin
					state_d = owm_pkg::ST_MUL_X;
				end
			end
			owm_pkg::ST_MUL_X: state_d = owm_pkg::ST_MUL_Y;
			owm_pkg::ST_MUL_Y: state_d = owm_pkg::ST_WHEEL;
			owm_pkg::ST_WHEEL: begin
				if (wheel_q == 2'd3) begin
					state_d = owm_pkg::ST_CHECK;
				end
			end
			owm_pkg::ST_CHECK: state_d = diff_q ? owm_pkg::ST_EMIT : owm_pkg::ST_IDLE;
			owm_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && byte_q == owm_pkg::IDX_CLOSE) begin
					state_d = owm_pkg::ST_IDLE;
				end
			end
			default: state_d = owm_pkg::ST_IDLE;
		endcase
	end

	// Store clamped velocities on a command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vel_q[i] <= '0;
			end
		end else if (in_acc && in_data.op == owm_pkg::OP_CMD) begin
			vel_q[0] <= clamp_vel(in_data.vel_x);
			vel_q[1] <= clamp_vel(in_data.vel_y);
			vel_q[2] <= clamp_vel(in_data.vel_rot);
		end
	end

	owm_mul u_mul (
		.sel_y    (state_q == owm_pkg::ST_MUL_Y),
		.sin_coef (sin_q),
		.cos_coef (cos_q),
		.vel_x    (vel_q[0]),
		.vel_y    (vel_q[1]),
		.product  (product)
	);

	// Hold the two axis products
	always_ff @(posedge clk) begin
		if (state_q == owm_pkg::ST_MUL_X) begin
			px_q <= product;
		end
		if (state_q == owm_pkg::ST_MUL_Y) begin
			py_q <= product;
		end
	end

	// Wheel adder: rotation plus signed axis products, floor shift, saturate
	always_comb begin
		rot_ext = {{(SUM_W-owm_pkg::VEL_W-15){vel_q[2][owm_pkg::VEL_W-1]}}, vel_q[2], 15'd0};
		px_ext  = SUM_W'(px_q);
		py_ext  = SUM_W'(py_q);
		sum     = rot_ext + (wheel_q[1] ? px_ext : -px_ext)
		        + ((wheel_q[0] ^ wheel_q[1]) ? -py_ext : py_ext);
		shr     = sum[SUM_W-1:14];
		if (shr[SHR_W-1:owm_pkg::SPEED_W-1] == '0
		    || shr[SHR_W-1:owm_pkg::SPEED_W-1] == '1) begin
			speed = shr[owm_pkg::SPEED_W-1:0];
		end else if (shr[SHR_W-1]) begin
			speed = {1'b1, {(owm_pkg::SPEED_W-1){1'b0}}};
		end else begin
			speed = {1'b0, {(owm_pkg::SPEED_W-1){1'b1}}};
		end
	end

	// Advance the wheel pass, record any change, and keep the new speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q <= '0;
			diff_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				sent_q[i] <= '0;
			end
		end else if (state_q == owm_pkg::ST_MUL_Y) begin
			wheel_q <= '0;
			diff_q  <= 1'b0;
		end else if (state_q == owm_pkg::ST_WHEEL) begin
			wheel_q         <= wheel_q + 2'd1;
			sent_q[wheel_q] <= speed;
			if (speed != sent_q[wheel_q]) begin
				diff_q <= 1'b1;
			end
		end
	end

	// Advance the frame byte slot as each word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (state_q == owm_pkg::ST_CHECK) begin
			byte_q <= owm_pkg::IDX_OPEN;
		end else if (out_valid && out_ready) begin
			byte_q <= byte_q + 3'd1;
		end
	end

	owm_framer u_framer (
		.byte_idx (byte_q),
		.speed    (sent_q),
		.deadband (deadband_q),
		.word     (out_data)
	);

endmodule

// ===== rtl/owm_mul.sv =====
// Shared coefficient-by-velocity multiplier used for both body axes.
// Depends on owm_pkg for widths.
module owm_mul (
	input  logic                                   sel_y,
	input  logic        [owm_pkg::COEF_W-1:0]      sin_coef,
	input  logic        [owm_pkg::COEF_W-1:0]      cos_coef,
	input  logic signed [owm_pkg::VEL_W-1:0]       vel_x,
	input  logic signed [owm_pkg::VEL_W-1:0]       vel_y,
	output logic signed [owm_pkg::PROD_W-1:0]      product
);

	logic signed [owm_pkg::COEF_W:0]  coef;
	logic signed [owm_pkg::VEL_W-1:0] vel;

	// Pick the operand pair, then multiply unsigned coefficient by signed velocity
	always_comb begin
		coef    = sel_y ? $signed({1'b0, cos_coef}) : $signed({1'b0, sin_coef});
		vel     = sel_y ? vel_y : vel_x;
		product = coef * vel;
	end

endmodule

// ===== rtl/owm_framer.sv =====
// Frame byte builder: start marks, direction byte, PWM bytes, end mark.
// Depends on owm_pkg for the word type and frame constants.
module owm_framer (
	input  logic [2:0]                 byte_idx,
	input  owm_pkg::speed_t            speed [4],
	input  logic [owm_pkg::DB_W-1:0]   deadband,
	output owm_pkg::out_word_t         word
);

	owm_pkg::speed_t                 sp;
	logic [owm_pkg::SPEED_W-1:0]     mag;
	logic [owm_pkg::SPEED_W+7:0]     scaled;
	logic [10:0]                     raw;
	logic [7:0]                      pwm;
	logic [1:0]                      wheel;
	logic [3:0]                      dir;

	// Scale the selected wheel speed to a PWM byte
	always_comb begin
		wheel  = 2'(byte_idx - 3'd3);
		sp     = speed[wheel];
		mag    = sp[owm_pkg::SPEED_W-1] ? owm_pkg::SPEED_W'(-sp) : owm_pkg::SPEED_W'(sp);
		scaled = {mag, 8'd0} - {8'd0, mag};
		raw    = scaled[owm_pkg::SPEED_W+7:15];
		pwm    = (raw > 11'(owm_pkg::PWM_FULL)) ? owm_pkg::PWM_FULL : raw[7:0];
		if (pwm < deadband) begin
			pwm = 8'd0;
		end
	end

	// Direction bit set for each wheel that is not negative
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dir[i] = ~speed[i][owm_pkg::SPEED_W-1];
		end
	end

	// Select the byte for this slot of the frame
	always_comb begin
		unique case (byte_idx)
			owm_pkg::IDX_OPEN:  word.frame_byte = owm_pkg::BYTE_OPEN;
			owm_pkg::IDX_MOTOR: word.frame_byte = owm_pkg::BYTE_MOTOR;
			owm_pkg::IDX_DIR:   word.frame_byte = {4'd0, dir};
			owm_pkg::IDX_CLOSE: word.frame_byte = owm_pkg::BYTE_CLOSE;
			default:            word.frame_byte = pwm;
		endcase
		word.last_byte = (byte_idx == owm_pkg::IDX_CLOSE);
	end

endmodule
